// ----- hw/rtl/jetc_pkg.sv -----
// Shared types, constants and step functions for the Julia escape-time classifier.
package jetc_pkg;

  localparam int MAX_ITERATIONS_DEF = 100;
  localparam int IDX_W = 11;       // iteration index, enough for 1024 iterations
  localparam int STOP_W = 7;
  localparam int Q_FRAC = 22;
  localparam int C_W = 26;
  localparam int START_W = 25;
  localparam int CFG_IDX_W = 2;

  localparam logic [63:0] ESCAPE_Q44 = 64'd200 << 44;
  localparam logic [63:0] TINY_Q44 = 64'd175922;  // 1e-8 in Q.44, rounded up

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C_REAL = 2'd0,
    CFG_C_IMAG = 2'd1,
    CFG_MIN_ITER = 2'd2,
    CFG_SPARE = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic valid;
    logic done;
    logic member;
    logic esc;
    logic [STOP_W-1:0] stop;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [63:0] xx;
    logic signed [63:0] yy;
    logic signed [63:0] xy;
  } stage_t;

  // squares and cross product of the current z
  function automatic stage_t mul_step(stage_t s);
    stage_t r;
    r = s;
    r.xx = 64'(s.x) * 64'(s.x);
    r.yy = 64'(s.y) * 64'(s.y);
    r.xy = 64'(s.x) * 64'(s.y);
    return r;
  endfunction

  // magnitude test of the z whose products are held, for iteration idx
  function automatic stage_t mag_check(stage_t s, logic [STOP_W-1:0] min_it,
                                       logic [IDX_W-1:0] idx);
    stage_t r;
    logic [63:0] mag;
    r = s;
    mag = $unsigned(s.xx) + $unsigned(s.yy);
    if (!s.done) begin
      if (mag > ESCAPE_Q44) begin
        r.done = 1'b1;
        r.esc = 1'b1;
        r.member = (idx >= IDX_W'(min_it));
        r.stop = idx[STOP_W-1:0];
      end else if (mag < TINY_Q44) begin
        r.done = 1'b1;
        r.member = 1'b0;
        r.stop = idx[STOP_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/jetc_ifs.sv -----
// Handshake interfaces: start points, results and register writes.
interface jetc_point_if;
  logic valid;
  logic ready;
  logic signed [jetc_pkg::START_W-1:0] start_real;
  logic signed [jetc_pkg::START_W-1:0] start_imag;
  modport source (output valid, start_real, start_imag, input ready);
  modport sink (input valid, start_real, start_imag, output ready);
endinterface

interface jetc_result_if;
  logic valid;
  logic ready;
  logic is_member;
  logic escaped;
  logic [jetc_pkg::STOP_W-1:0] escape_iteration;
  logic signed [31:0] final_real;
  logic signed [31:0] final_imag;
  modport source (output valid, is_member, escaped, escape_iteration, final_real,
                  final_imag, input ready);
  modport sink (input valid, is_member, escaped, escape_iteration, final_real,
                final_imag, output ready);
endinterface

interface jetc_cfg_if;
  logic valid;
  logic ready;
  logic [jetc_pkg::CFG_IDX_W-1:0] index;
  logic [jetc_pkg::C_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/jetc_iter.sv -----
// One iteration: magnitude test of the previous z (skipped in the first iteration), update, then products of the new z.
module jetc_iter #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic signed [jetc_pkg::C_W-1:0] c_real,
  input  logic signed [jetc_pkg::C_W-1:0] c_imag,
  input  logic [jetc_pkg::STOP_W-1:0] min_it,
  input  jetc_pkg::stage_t din,
  output jetc_pkg::stage_t dout
);

  localparam int CHK = (IDX > 0) ? IDX - 1 : 0;

  jetc_pkg::stage_t chk;
  jetc_pkg::stage_t upd;
  jetc_pkg::stage_t mid;
  logic signed [63:0] diff;

  always_comb begin
    chk = (IDX > 0) ? jetc_pkg::mag_check(din, min_it, jetc_pkg::IDX_W'(CHK)) : din;
    diff = din.xx - din.yy;
    upd = chk;
    if (!chk.done) begin
      upd.x = 32'(diff >>> jetc_pkg::Q_FRAC) + 32'(c_real);
      upd.y = 32'(din.xy >>> (jetc_pkg::Q_FRAC - 1)) + 32'(c_imag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      mid <= upd;
      dout <= jetc_pkg::mul_step(mid);
    end
  end

endmodule

// ----- hw/rtl/julia_escape_time_classifier.sv -----
// Top level of the Julia escape-time classifier: unrolled iteration pipeline.
//
//  channel | dir | fields                                          | accepted when
//  point   | in  | start_real, start_imag (Q3.22, 25 bit)          | valid && ready
//  result  | out | is_member, escaped, escape_iteration, final_*   | valid && ready
//  cfg     | in  | index (0 c_real, 1 c_imag, 2 min_iterations)    | valid && ready
//
// One point per cycle while results are taken; registers in order: entry register,
// start products, two register stages per unrolled iteration (update, then multiply)
// and the output register.
// Reset clears all valid bits and the registers (c = 0, min_iterations = 0).
// A held result freezes the whole pipeline, so nothing is dropped or repeated.
// cfg is always ready.
module julia_escape_time_classifier #(
  parameter int MAX_ITERATIONS = jetc_pkg::MAX_ITERATIONS_DEF
) (
  input logic clk,
  input logic rst,
  jetc_point_if.sink point,
  jetc_result_if.source result,
  jetc_cfg_if.sink cfg
);

  logic signed [jetc_pkg::C_W-1:0] c_real;
  logic signed [jetc_pkg::C_W-1:0] c_imag;
  logic [jetc_pkg::STOP_W-1:0] min_it;

  logic en;                                   // whole pipe advances together
  jetc_pkg::stage_t s_in;                     // captured request
  jetc_pkg::stage_t chain [MAX_ITERATIONS+1]; // chain[0]: products of start
  jetc_pkg::stage_t last;
  jetc_pkg::stage_t out_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real <= '0;
      c_imag <= '0;
      min_it <= '0;
    end else if (cfg.valid) begin
      unique case (jetc_pkg::cfg_idx_t'(cfg.index))
        jetc_pkg::CFG_C_REAL:   c_real <= cfg.data;
        jetc_pkg::CFG_C_IMAG:   c_imag <= cfg.data;
        jetc_pkg::CFG_MIN_ITER: min_it <= cfg.data[jetc_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  assign en = !out_q.valid || result.ready;
  assign point.ready = en;

  // entry: start z, default verdict is "ran to the limit, member"
  always_ff @(posedge clk) begin
    if (rst) begin
      s_in.valid <= 1'b0;
      chain[0].valid <= 1'b0;
    end else if (en) begin
      s_in.valid <= point.valid;
      s_in.done <= 1'b0;
      s_in.member <= 1'b1;
      s_in.esc <= 1'b0;
      s_in.stop <= jetc_pkg::STOP_W'(MAX_ITERATIONS - 1);
      s_in.x <= 32'(point.start_real);
      s_in.y <= 32'(point.start_imag);
      s_in.xx <= '0;
      s_in.yy <= '0;
      s_in.xy <= '0;
      chain[0] <= jetc_pkg::mul_step(s_in);
    end
  end

  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_iter
    jetc_iter #(.IDX(g)) u_iter (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .c_real (c_real),
      .c_imag (c_imag),
      .min_it (min_it),
      .din    (chain[g]),
      .dout   (chain[g+1])
    );
  end

  // test of the last iteration's z, then the output register
  assign last = jetc_pkg::mag_check(chain[MAX_ITERATIONS], min_it,
                                    jetc_pkg::IDX_W'(MAX_ITERATIONS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_q.valid <= 1'b0;
    end else if (en) begin
      out_q <= last;
    end
  end

  assign result.valid = out_q.valid;
  assign result.is_member = out_q.member;
  assign result.escaped = out_q.esc;
  assign result.escape_iteration = out_q.stop;
  assign result.final_real = out_q.x;
  assign result.final_imag = out_q.y;

`ifndef NO_ASSERTIONS
  // an escaping member never escaped before the configured minimum
  a_esc_member: assert property (@(posedge clk) disable iff (rst)
    out_q.valid && out_q.esc && out_q.member |-> out_q.stop >= min_it)
    else $error("escaping member below minimum iteration");
  // a point that never stopped reports the last index
  a_no_stop: assert property (@(posedge clk) disable iff (rst)
    out_q.valid && !out_q.esc && out_q.member |->
      out_q.stop == jetc_pkg::STOP_W'(MAX_ITERATIONS - 1))
    else $error("non-stopping point with wrong index");
  // an accepted request enters the pipe
  a_enter: assert property (@(posedge clk) disable iff (rst)
    point.valid && point.ready |=> s_in.valid)
    else $error("accepted request lost at entry");
`endif

endmodule
